// ===== rtl/bmmd_pkg.sv =====
package bmmd_pkg;

  // Storage size of the main RAM.
  localparam int unsigned RAM_BYTES_DEF = 65536;

  // Access kinds carried in the request opcode.
  localparam logic [1:0] OP_CPU_READ   = 2'd0;
  localparam logic [1:0] OP_CPU_WRITE  = 2'd1;
  localparam logic [1:0] OP_VID_FLAT   = 2'd2;
  localparam logic [1:0] OP_VID_BANKED = 2'd3;

  // Target codes reported with each result.
  localparam logic [3:0] TGT_RAM    = 4'd0;
  localparam logic [3:0] TGT_BASIC  = 4'd1;
  localparam logic [3:0] TGT_CHAR   = 4'd2;
  localparam logic [3:0] TGT_KERNEL = 4'd3;
  localparam logic [3:0] TGT_VIC    = 4'd4;
  localparam logic [3:0] TGT_SID    = 4'd5;
  localparam logic [3:0] TGT_COLOUR = 4'd6;
  localparam logic [3:0] TGT_CIA1   = 4'd7;
  localparam logic [3:0] TGT_CIA2   = 4'd8;
  localparam logic [3:0] TGT_IO1    = 4'd9;
  localparam logic [3:0] TGT_IO2    = 4'd10;

  // Banking port value after reset and the address it is mirrored at.
  localparam logic [7:0]  BANK_PORT_RESET = 8'h07;
  localparam logic [15:0] BANK_PORT_ADDR  = 16'h0001;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] target_offset;
    logic [7:0]  read_data;
    logic        ram_written;
  } out_rsp_t;

endpackage

// ===== rtl/banked_memory_map_decoder.sv =====
// Each accepted request has its result registered and shown in the cycle after acceptance.
// Throughput: one request per cycle; busy is high only while reset is held, since the
// single RAM port serves either the read or the write of each request and the decode
// settles in that cycle.
// Reset (synchronous, rst_n low) sets the banking port to 7, the video bank to 0 and
// clears the result strobe; RAM contents are undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
module banked_memory_map_decoder #(
  parameter int unsigned RAM_BYTES = bmmd_pkg::RAM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bmmd_pkg::in_req_t in_req,
  output logic              out_strobe,
  output bmmd_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  localparam int unsigned AW = $clog2(RAM_BYTES);

  logic [7:0] ram [RAM_BYTES];

  logic                accept;
  logic [7:0]          bank_port_r;
  logic [1:0]          video_bank_r;
  logic                valid_r;
  bmmd_pkg::out_rsp_t  rsp_r;
  logic                use_ram_r;
  logic                use_port_r;
  logic [7:0]          port_q_r;
  logic [7:0]          ram_q_r;

  logic [15:0]         va;
  logic [15:0]         ram_addr;
  logic                io_on;
  logic                in_io;
  logic [3:0]          io_tgt;
  logic [15:0]         io_off;
  logic [3:0]          tgt;
  logic [15:0]         off;
  logic                do_read;
  logic                do_write;

  assign busy      = !rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // I/O is mapped in when the low three port bits exceed four.
  assign io_on = bank_port_r[2] && (bank_port_r[1] || bank_port_r[0]);
  assign in_io = (in_req.address[15:12] == 4'hd);

  // Split of the I/O window into device regions.
  always_comb begin
    unique case (in_req.address[11:8])
      4'h0, 4'h1, 4'h2, 4'h3: begin
        io_tgt = bmmd_pkg::TGT_VIC;
        io_off = {6'd0, in_req.address[9:0]};
      end
      4'h4, 4'h5, 4'h6, 4'h7: begin
        io_tgt = bmmd_pkg::TGT_SID;
        io_off = {6'd0, in_req.address[9:0]};
      end
      4'h8, 4'h9, 4'ha, 4'hb: begin
        io_tgt = bmmd_pkg::TGT_COLOUR;
        io_off = {6'd0, in_req.address[9:0]};
      end
      4'hc: begin
        io_tgt = bmmd_pkg::TGT_CIA1;
        io_off = in_req.address;
      end
      4'hd: begin
        io_tgt = bmmd_pkg::TGT_CIA2;
        io_off = in_req.address;
      end
      4'he: begin
        io_tgt = bmmd_pkg::TGT_IO1;
        io_off = {8'd0, in_req.address[7:0]};
      end
      default: begin
        io_tgt = bmmd_pkg::TGT_IO2;
        io_off = {8'd0, in_req.address[7:0]};
      end
    endcase
  end

  // Address seen by the video chip; banked reads replace the top two bits.
  assign va = (in_req.opcode == bmmd_pkg::OP_VID_BANKED) ?
              {video_bank_r, in_req.address[13:0]} : in_req.address;

  // Target decode for each access kind.
  always_comb begin
    tgt      = bmmd_pkg::TGT_RAM;
    off      = in_req.address;
    ram_addr = in_req.address;
    do_read  = 1'b0;
    do_write = 1'b0;
    unique case (in_req.opcode)
      bmmd_pkg::OP_CPU_READ: begin
        if (in_req.address[15:13] == 3'b101) begin
          if (bank_port_r[1:0] == 2'b11) begin
            tgt = bmmd_pkg::TGT_BASIC;
            off = {3'd0, in_req.address[12:0]};
          end
        end else if (in_io) begin
          if (io_on) begin
            tgt = io_tgt;
            off = io_off;
          end else if (bank_port_r[1]) begin
            tgt = bmmd_pkg::TGT_CHAR;
            off = {4'd0, in_req.address[11:0]};
          end
        end else if (in_req.address[15:13] == 3'b111) begin
          if (bank_port_r[1]) begin
            tgt = bmmd_pkg::TGT_KERNEL;
            off = {3'd0, in_req.address[12:0]};
          end
        end
        do_read = (tgt == bmmd_pkg::TGT_RAM);
      end
      bmmd_pkg::OP_CPU_WRITE: begin
        if (in_io && io_on) begin
          tgt = io_tgt;
          off = io_off;
        end
        do_write = (tgt == bmmd_pkg::TGT_RAM) || (tgt == bmmd_pkg::TGT_VIC) ||
                   (tgt == bmmd_pkg::TGT_COLOUR);
      end
      default: begin
        ram_addr = va;
        if ((va[15:12] == 4'h1) || (va[15:12] == 4'h9)) begin
          tgt = bmmd_pkg::TGT_CHAR;
          off = {4'd0, va[11:0]};
        end else begin
          off = va;
        end
        do_read = (tgt == bmmd_pkg::TGT_RAM);
      end
    endcase
  end

  // RAM port: a write stores the byte, a read registers the addressed byte.
  always_ff @(posedge clk) begin
    if (accept && do_write) begin
      ram[in_req.address[AW-1:0]] <= in_req.write_data;
    end
    if (accept && do_read) begin
      ram_q_r <= ram[ram_addr[AW-1:0]];
    end
  end

  // Control state: banking port, video bank and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_port_r  <= bmmd_pkg::BANK_PORT_RESET;
      video_bank_r <= 2'd0;
      valid_r      <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept && do_write && (in_req.address == bmmd_pkg::BANK_PORT_ADDR)) begin
        bank_port_r <= in_req.write_data;
      end
      if (cfg_valid && cfg_ready) begin
        video_bank_r <= cfg_data;
      end
    end
  end

  // Result stage; the port mirror is captured with the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r.target        <= tgt;
      rsp_r.target_offset <= off;
      rsp_r.read_data     <= 8'd0;
      rsp_r.ram_written   <= do_write;
      use_ram_r           <= do_read;
      use_port_r          <= do_read && (ram_addr == bmmd_pkg::BANK_PORT_ADDR);
      port_q_r            <= bank_port_r;
    end
  end

  // Read data comes from the mirrored port, the RAM or is zero.
  always_comb begin
    out_rsp = rsp_r;
    priority if (use_port_r) begin
      out_rsp.read_data = port_q_r;
    end else if (use_ram_r) begin
      out_rsp.read_data = ram_q_r;
    end else begin
      out_rsp.read_data = 8'd0;
    end
  end

  assign out_strobe = valid_r;

endmodule

// ===== rtl/bmmd_checker.sv =====
module bmmd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input bmmd_pkg::out_rsp_t out_rsp
);

  // Every accepted request gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk)
    (rst_n && start && !busy) |=> out_strobe)
    else $error("accepted request produced no result");

  // No result appears without a request accepted the cycle before.
  a_no_spurious: assert property (@(posedge clk)
    (!rst_n || !(start && !busy)) |=> !out_strobe)
    else $error("result strobe without an accepted request");

  // A write returns no read data.
  a_write_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.ram_written) |-> (out_rsp.read_data == 8'd0))
    else $error("write reported read data");

  // Read data is nonzero only for RAM hits.
  a_data_only_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_rsp.target != bmmd_pkg::TGT_RAM)) |->
    (out_rsp.read_data == 8'd0))
    else $error("read data reported for a non-RAM target");

  // Only RAM, VIC and colour targets store into RAM.
  a_store_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.ram_written) |->
    ((out_rsp.target == bmmd_pkg::TGT_RAM) || (out_rsp.target == bmmd_pkg::TGT_VIC) ||
     (out_rsp.target == bmmd_pkg::TGT_COLOUR)))
    else $error("RAM store reported for a device target");

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);
